@@ rtl/kbd_pkg.sv @@
package kbd_pkg;

  localparam int unsigned DistW = 32;
  localparam int unsigned IdxW = 20;
  localparam int unsigned RankW = 6;
  localparam int unsigned ListSizeDefault = 8;

  localparam logic KindStatus = 1'b0;
  localparam logic KindEntry = 1'b1;

  // One slot of the list.
  typedef struct packed {
    logic             valid;
    logic [DistW-1:0] distance;
    logic [IdxW-1:0]  idx;
  } entry_t;

  // Token that walks down the chain, one cell per cycle. While shift is low
  // it is the new candidate looking for its place; once placed, the token
  // carries the displaced entry further down.
  typedef struct packed {
    logic   active;
    logic   shift;
    entry_t ent;
  } token_t;

  // Commands that the sequencer broadcasts to every cell.
  typedef struct packed {
    logic clear;
    logic rotate;
  } cell_ctrl_t;

endpackage

@@ rtl/kbd_in_if.sv @@
interface kbd_in_if import kbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             new_query;
  logic             flush;
  logic [DistW-1:0] distance;
  logic [IdxW-1:0]  point_index;

  modport source (output valid, new_query, flush, distance, point_index, input ready);
  modport sink (input valid, new_query, flush, distance, point_index, output ready);
endinterface

@@ rtl/kbd_out_if.sv @@
interface kbd_out_if import kbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [RankW-1:0] rank;
  logic [IdxW-1:0]  out_index;
  logic [DistW-1:0] out_distance;
  logic             entry_valid;
  logic             last;

  modport source (output valid, kind, rank, out_index, out_distance, entry_valid, last,
                  input ready);
  modport sink (input valid, kind, rank, out_index, out_distance, entry_valid, last,
                output ready);
endinterface

@@ rtl/k_best_distance_list.sv @@
// K-best distance list.
//
// The block keeps the LIST_SIZE nearest candidates of one query in a chain
// of cells, sorted by ascending distance. Items arrive as transactions on
// in_i and results leave as transactions on out_o, both valid/ready.
// An insert transaction sends a token down the chain, one cell per cycle,
// then loads the status result; the next item is taken only once the
// status result is in the output register. Ties go to the new item, and a
// point index already held in front of the insertion place leaves the list
// unchanged. A flush transaction reads the list out as LIST_SIZE entry
// results, one per cycle while the output register is free, by rotating
// the chain toward cell zero; after LIST_SIZE steps the list is back in its
// original order, and the next item is taken once the last entry result is
// in the output register.
// The new_query flag empties the list in the cycle the transaction is taken.
// The output register lets the next input transaction be taken while the
// last result still waits. When the receiver stalls, the sequencer holds
// until the output register frees up. Reset leaves the list empty.
module k_best_distance_list import kbd_pkg::*; #(
  parameter int unsigned LIST_SIZE = ListSizeDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  kbd_in_if.sink    in_i,
  kbd_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(LIST_SIZE + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StStat = 2'd2;
  localparam logic [1:0] StRead = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  token_t     tok0_q, tok0_d;
  cell_ctrl_t ctrl;
  token_t     tok [LIST_SIZE+1];
  entry_t     entry [LIST_SIZE];

  logic in_acc;
  logic out_free;
  logic cnt_end;

  // Output register.
  logic             ov_q, ov_d;
  logic             kind_q, kind_d;
  logic [RankW-1:0] rank_q, rank_d;
  logic [IdxW-1:0]  oidx_q, oidx_d;
  logic [DistW-1:0] odist_q, odist_d;
  logic             evld_q, evld_d;
  logic             last_q, last_d;

  assign in_i.ready = (state_q == StIdle);
  assign in_acc = in_i.valid && in_i.ready;
  assign out_free = !ov_q || out_o.ready;
  assign cnt_end = (cnt_q == CntW'(LIST_SIZE - 1));

  assign tok[0] = tok0_q;

  // The chain: each cell hands its token to the next cell and, during
  // readout, takes the entry of the next cell, the last one wrapping around.
  for (genvar i = 0; i < LIST_SIZE; i++) begin : g_cell
    kbd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .tok_i   (tok[i]),
      .rot_i   (entry[(i + 1) % LIST_SIZE]),
      .tok_o   (tok[i+1]),
      .entry_o (entry[i])
    );
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    tok0_d = '0;
    ctrl = '0;
    ov_d = ov_q && !out_o.ready;
    kind_d = kind_q;
    rank_d = rank_q;
    oidx_d = oidx_q;
    odist_d = odist_q;
    evld_d = evld_q;
    last_d = last_q;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          ctrl.clear = in_i.new_query;
          cnt_d = '0;
          if (in_i.flush) begin
            state_d = StRead;
          end else begin
            tok0_d = '{active: 1'b1, shift: 1'b0,
                       ent: '{valid: 1'b1, distance: in_i.distance, idx: in_i.point_index}};
            state_d = StWalk;
          end
        end
      end
      StWalk: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_end) begin
          state_d = StStat;
        end
      end
      StStat: begin
        if (out_free) begin
          ov_d = 1'b1;
          kind_d = KindStatus;
          rank_d = '0;
          evld_d = entry[LIST_SIZE-1].valid;
          oidx_d = entry[LIST_SIZE-1].valid ? entry[LIST_SIZE-1].idx : '0;
          odist_d = entry[LIST_SIZE-1].valid ? entry[LIST_SIZE-1].distance : '0;
          last_d = 1'b1;
          state_d = StIdle;
        end
      end
      StRead: begin
        if (out_free) begin
          ov_d = 1'b1;
          kind_d = KindEntry;
          rank_d = RankW'(cnt_q);
          evld_d = entry[0].valid;
          oidx_d = entry[0].valid ? entry[0].idx : '0;
          odist_d = entry[0].valid ? entry[0].distance : '0;
          last_d = cnt_end;
          ctrl.rotate = 1'b1;
          cnt_d = cnt_q + CntW'(1);
          if (cnt_end) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      tok0_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      tok0_q <= tok0_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    rank_q <= rank_d;
    oidx_q <= oidx_d;
    odist_q <= odist_d;
    evld_q <= evld_d;
    last_q <= last_d;
  end

  assign out_o.valid = ov_q;
  assign out_o.kind = kind_q;
  assign out_o.rank = rank_q;
  assign out_o.out_index = oidx_q;
  assign out_o.out_distance = odist_q;
  assign out_o.entry_valid = evld_q;
  assign out_o.last = last_q;

  // A token enters the chain only at the start of a walk.
  a_tok_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok0_q.active |-> (state_q == StWalk))
    else $error("token injected outside a walk");

  // A status result is always the last result of its item.
  a_stat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind == KindStatus)) |-> out_o.last)
    else $error("status result without last");

  // The final readout entry is the last slot.
  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind == KindEntry) && out_o.last) |->
    (out_o.rank == RankW'(LIST_SIZE - 1)))
    else $error("readout ends at the wrong rank");

  // Outside readout, occupied slots form a prefix of the list.
  for (genvar i = 0; i + 1 < LIST_SIZE; i++) begin : g_prefix
    a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ((state_q != StRead) && entry[i+1].valid) |-> entry[i].valid)
      else $error("occupied slots do not form a prefix");
  end

endmodule

@@ rtl/kbd_cell.sv @@
module kbd_cell import kbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  token_t     tok_i,
  input  entry_t     rot_i,
  output token_t     tok_o,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;
  token_t tok_q, tok_d;

  logic dup;
  logic place;

  assign dup = entry_q.valid && (entry_q.idx == tok_i.ent.idx);
  assign place = !entry_q.valid || (entry_q.distance >= tok_i.ent.distance);

  always_comb begin
    entry_d = entry_q;
    tok_d = '0;
    if (ctrl_i.clear) begin
      entry_d.valid = 1'b0;
    end else if (ctrl_i.rotate) begin
      entry_d = rot_i;
    end else if (tok_i.active) begin
      if (tok_i.shift) begin
        entry_d = tok_i.ent;
        tok_d = '{active: entry_q.valid, shift: 1'b1, ent: entry_q};
      end else if (dup) begin
        // The index is already held in front of the stop point: the wave ends here.
        tok_d = '0;
      end else if (place) begin
        entry_d = tok_i.ent;
        tok_d = '{active: entry_q.valid, shift: 1'b1, ent: entry_q};
      end else begin
        tok_d = tok_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      tok_q <= '0;
    end else begin
      entry_q <= entry_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign entry_o = entry_q;

endmodule
